// ----- rtl/mie_pkg.sv -----
// Shared types and constants for the MIPS execute block.
package mie_pkg;

    typedef enum logic [5:0] {
        OP_ADD, OP_ADDI, OP_ADDIU, OP_SUB, OP_SUBI, OP_SUBIU, OP_MULT, OP_DIV,
        OP_AND, OP_ANDI, OP_OR, OP_ORI, OP_XOR, OP_XORI, OP_NOR, OP_SLT,
        OP_SLTI, OP_SLTIU, OP_SLL, OP_SRL, OP_SRA, OP_MFHI, OP_MFLO, OP_J,
        OP_JAL, OP_JR, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_LW, OP_LB,
        OP_LBU, OP_LH, OP_LHU, OP_LUI, OP_SW, OP_SB, OP_SH
    } t_op;

    typedef struct packed {
        logic [5:0]  cmd;
        logic [4:0]  rd_field;
        logic [4:0]  rs_field;
        logic [4:0]  rt_field;
        logic [31:0] imm_value;
        logic [4:0]  shift_amount;
        logic [25:0] jump_target;
    } t_in;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        logic [31:0] hi_out;
        logic [31:0] lo_out;
        logic        div_zero;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_MEM, ST_WB, ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic read_regs;
        logic exec;
        logic mul_start;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic mem_done;
        logic writeback;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic is_load;
        logic mul_done;
        logic div_done;
    } t_stat;

    localparam logic [31:0] PC_REGION = 32'hf000_0000;
    localparam logic [4:0]  LINK_REG  = 5'd31;

endpackage

// ----- rtl/mie_if.sv -----
// Valid/ready channel interfaces.
interface mie_in_if;
    import mie_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface mie_out_if;
    import mie_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/mie_ram.sv -----
// Generic single-port RAM with registered read.
module mie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- rtl/mie_ctrl.sv -----
// Controller state machine for the execute block.
module mie_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mie_pkg::t_stat  i_stat,
    output mie_pkg::t_cmd   o_cmd
);
    import mie_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read_regs = 1'b1;
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_stat.is_mul) begin
                    o_cmd.mul_start = 1'b1;
                    n_state = ST_MUL;
                end else if (i_stat.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = i_stat.is_load ? ST_MEM : ST_WB;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_done) n_state = ST_WB;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) n_state = ST_WB;
            end
            ST_MEM: begin
                o_cmd.mem_done = 1'b1;
                n_state = ST_WB;
            end
            ST_WB: begin
                o_cmd.writeback = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- rtl/mie_dp.sv -----
// Datapath: register file, hi/lo, pc, ALU, mult/div units and data memory.
module mie_dp #(
    parameter int MEM_WORDS = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mie_pkg::t_in   i_in,
    input  mie_pkg::t_cmd  i_cmd,
    output mie_pkg::t_stat o_stat,
    output mie_pkg::t_out  o_out
);
    import mie_pkg::*;
    localparam int AW = $clog2(MEM_WORDS);

    t_in         r_in;
    logic [31:0] r_regs [32];
    logic [31:0] r_a, r_b, r_hi, r_lo, r_pc;
    logic        r_wr, r_dz;
    logic [4:0]  r_widx;
    logic [31:0] r_wval;
    t_out        r_out;

    // multiply: 16x32 partial products, one per cycle
    logic [63:0] r_acc;
    logic [31:0] r_mcand;
    logic [31:0] r_mplier;
    logic [1:0]  r_mcnt;
    logic        r_mneg;

    // divide: restoring, one quotient bit per cycle on magnitudes
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [5:0]  r_dcnt;
    logic        r_qneg, r_rneg;

    logic [31:0] w_mem_rdata, w_addr_full;
    logic        w_mem_we;
    t_op         w_op;

    assign w_op        = t_op'(r_in.cmd);
    assign w_addr_full = r_a + r_in.imm_value;
    assign w_mem_we    = i_cmd.exec &&
        (w_op == OP_SW || w_op == OP_SB || w_op == OP_SH);

    logic [31:0] w_store;
    always_comb begin
        case (w_op)
            OP_SB:   w_store = {24'd0, r_b[7:0]};
            OP_SH:   w_store = {16'd0, r_b[15:0]};
            default: w_store = r_b;
        endcase
    end

    mie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_addr (w_addr_full[AW+1:2]),
        .i_wdata(w_store),
        .o_rdata(w_mem_rdata)
    );

    assign o_stat.is_mul   = (w_op == OP_MULT);
    assign o_stat.is_div   = (w_op == OP_DIV) && (r_b != 32'd0);
    assign o_stat.is_load  = (w_op == OP_LW || w_op == OP_LB || w_op == OP_LBU ||
                              w_op == OP_LH || w_op == OP_LHU);
    assign o_stat.mul_done = (r_mcnt == 2'd3);
    assign o_stat.div_done = (r_dcnt == 6'd0);

    logic [31:0] w_pc4, w_br;
    assign w_pc4 = r_pc + 32'd4;
    assign w_br  = w_pc4 + {r_in.imm_value[29:0], 2'b00};

    // ops handled directly in the execute state
    logic        e_wr;
    logic [4:0]  e_idx;
    logic [31:0] e_val, e_pc;
    always_comb begin
        e_wr  = 1'b1;
        e_idx = r_in.rd_field;
        e_val = '0;
        e_pc  = w_pc4;
        unique case (w_op)
            OP_ADD:              e_val = r_a + r_b;
            OP_ADDI, OP_ADDIU:   e_val = r_a + r_in.imm_value;
            OP_SUB:              e_val = r_a - r_b;
            OP_SUBI, OP_SUBIU:   e_val = r_a - r_in.imm_value;
            OP_AND:              e_val = r_a & r_b;
            OP_ANDI:             e_val = r_a & r_in.imm_value;
            OP_OR:               e_val = r_a | r_b;
            OP_ORI:              e_val = r_a | r_in.imm_value;
            OP_XOR:              e_val = r_a ^ r_b;
            OP_XORI:             e_val = r_a ^ r_in.imm_value;
            OP_NOR:              e_val = ~(r_a | r_b);
            OP_SLT:              e_val = {31'd0, $signed(r_a) < $signed(r_b)};
            OP_SLTI: begin
                e_idx = r_in.rt_field;
                e_val = {31'd0, $signed(r_a) < $signed(r_in.imm_value)};
            end
            OP_SLTIU: begin
                e_idx = r_in.rt_field;
                e_val = {31'd0, r_a < r_in.imm_value};
            end
            OP_SLL:              e_val = r_a << r_in.shift_amount;
            OP_SRL:              e_val = r_a >> r_in.shift_amount;
            OP_SRA:              e_val = $unsigned($signed(r_a) >>> r_in.shift_amount);
            OP_MFHI:             e_val = r_hi;
            OP_MFLO:             e_val = r_lo;
            OP_J: begin
                e_wr = 1'b0;
                e_pc = (w_pc4 & PC_REGION) | {4'd0, r_in.jump_target, 2'b00};
            end
            OP_JAL: begin
                e_idx = LINK_REG;
                e_val = w_pc4;
                e_pc  = (w_pc4 & PC_REGION) | {4'd0, r_in.jump_target, 2'b00};
            end
            OP_JR: begin
                e_wr = 1'b0;
                e_pc = r_a;
            end
            OP_BEQ: begin
                e_wr = 1'b0;
                if (r_a == r_b) e_pc = w_br;
            end
            OP_BNE: begin
                e_wr = 1'b0;
                if (r_a != r_b) e_pc = w_br;
            end
            OP_BLEZ: begin
                e_wr = 1'b0;
                if ($signed(r_a) < 32'sd1) e_pc = w_br;
            end
            OP_BGTZ: begin
                e_wr = 1'b0;
                if ($signed(r_a) > 32'sd0) e_pc = w_br;
            end
            OP_LW, OP_LB, OP_LBU, OP_LH, OP_LHU: e_idx = r_in.rt_field;
            OP_LUI: begin
                e_idx = r_in.rt_field;
                e_val = {r_in.imm_value[15:0], 16'd0};
            end
            default:             e_wr = 1'b0;
        endcase
    end

    logic [31:0] w_load;
    always_comb begin
        case (w_op)
            OP_LB:   w_load = {{24{w_mem_rdata[7]}}, w_mem_rdata[7:0]};
            OP_LBU:  w_load = {24'd0, w_mem_rdata[7:0]};
            OP_LH:   w_load = {{16{w_mem_rdata[15]}}, w_mem_rdata[15:0]};
            OP_LHU:  w_load = {16'd0, w_mem_rdata[15:0]};
            default: w_load = w_mem_rdata;
        endcase
    end

    logic [47:0] w_pp;
    logic [31:0] w_trial_rem;
    logic [32:0] w_trial;
    assign w_pp        = r_mplier[15:0] * r_mcand;
    assign w_trial_rem = {r_rem[30:0], r_quo[31]};
    assign w_trial     = {1'b0, w_trial_rem} - {1'b0, r_dvs};

    logic [63:0] w_prod;
    assign w_prod = r_mneg ? (~r_acc + 64'd1) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) r_regs[i] <= '0;
            r_hi <= '0;
            r_lo <= '0;
            r_pc <= '0;
        end else begin
            if (i_cmd.load_in) r_in <= i_in;
            if (i_cmd.read_regs) begin
                r_a <= r_regs[r_in.rs_field];
                r_b <= r_regs[r_in.rt_field];
            end
            if (i_cmd.exec) begin
                r_wr   <= e_wr;
                r_widx <= e_idx;
                r_wval <= e_val;
                // div only reaches here with a zero divisor
                r_dz   <= (w_op == OP_DIV);
                r_pc   <= e_pc;
            end
            if (i_cmd.mem_done) r_wval <= w_load;
            // start multiply on magnitudes
            if (i_cmd.mul_start) begin
                r_mcand  <= r_a[31] ? -r_a : r_a;
                r_mplier <= r_b[31] ? -r_b : r_b;
                r_mneg   <= r_a[31] ^ r_b[31];
                r_acc    <= '0;
                r_mcnt   <= '0;
            end
            if (i_cmd.mul_step) begin
                r_acc    <= r_acc + ({16'd0, w_pp} << {r_mcnt, 4'b0000});
                r_mplier <= r_mplier >> 16;
                r_mcnt   <= r_mcnt + 2'd1;
                if (r_mcnt == 2'd1) begin
                    r_wr <= 1'b0;
                    r_dz <= 1'b0;
                    r_pc <= w_pc4;
                end
            end
            if (i_cmd.div_start) begin
                r_rem  <= '0;
                r_quo  <= r_a[31] ? -r_a : r_a;
                r_dvs  <= r_b[31] ? -r_b : r_b;
                r_qneg <= r_a[31] ^ r_b[31];
                r_rneg <= r_a[31];
                r_dcnt <= 6'd32;
                r_wr   <= 1'b0;
                r_dz   <= 1'b0;
                r_pc   <= w_pc4;
            end
            if (i_cmd.div_step && r_dcnt != 6'd0) begin
                r_dcnt <= r_dcnt - 6'd1;
                if (!w_trial[32]) begin
                    r_rem <= w_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_trial_rem;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            if (i_cmd.writeback) begin
                r_out.next_pc     <= r_pc;
                r_out.div_zero    <= r_dz;
                if (r_wr && r_widx != 5'd0) begin
                    r_regs[r_widx]    <= r_wval;
                    r_out.reg_write   <= 1'b1;
                    r_out.write_index <= r_widx;
                    r_out.write_value <= r_wval;
                end else begin
                    r_out.reg_write   <= 1'b0;
                    r_out.write_index <= '0;
                    r_out.write_value <= '0;
                end
                if (w_op == OP_MULT) begin
                    r_hi <= w_prod[63:32];
                    r_lo <= w_prod[31:0];
                    r_out.hi_out <= w_prod[63:32];
                    r_out.lo_out <= w_prod[31:0];
                end else if (w_op == OP_DIV && !r_dz) begin
                    r_hi <= r_rneg ? -r_rem : r_rem;
                    r_lo <= r_qneg ? -r_quo : r_quo;
                    r_out.hi_out <= r_rneg ? -r_rem : r_rem;
                    r_out.lo_out <= r_qneg ? -r_quo : r_quo;
                end else begin
                    r_out.hi_out <= r_hi;
                    r_out.lo_out <= r_lo;
                end
            end
        end
    end

    assign o_out = r_out;
endmodule

// ----- rtl/mie_top.sv -----
// Top level of the MIPS execute block.
// One decoded instruction at a time: IDLE, register read, execute, write back,
// output. A new item is taken only once the result has been taken. Loads add a
// state for the registered data-memory read, mult adds a state that accumulates
// 16-bit partial products, and div adds a state for its bit-serial restoring
// divider (a zero divisor skips it). Register file, hi, lo and pc clear on
// reset; data memory is not initialized.
module mips_instruction_execute_top #(
    parameter int MEM_WORDS = 1024
) (
    input logic         i_clk,
    input logic         i_rst_n,
    mie_in_if.sink      in_ch,
    mie_out_if.source   out_ch
);
    import mie_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mie_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.data),
        .i_cmd  (w_cmd),
        .o_stat (w_stat),
        .o_out  (out_ch.data)
    );

`ifndef SYNTH
    // never take a new item while a result is shown
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    // after a transfer in, neither ready nor valid is raised in the next cycle
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready && !out_ch.valid)
        else $error("bad sequence after transfer");
    // r0 is never reported written
    a_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.data.reg_write) |-> (out_ch.data.write_index != 5'd0))
        else $error("write to r0 reported");
`endif
endmodule
